[design/dep_pkg.sv]
// Shared types and constants for the dual encoder position and speed block.
package dep_pkg;

    // Field widths fixed by the interface.
    localparam int POS_W     = 32;
    localparam int RPM_W     = 26;
    localparam int CPR_W     = 16;
    localparam int TIMEOUT_W = 32;
    localparam int NUM_CH    = 2;

    // Speed arithmetic: 60 * ((1000000 / period) / counts_per_rev).
    localparam int              QUOT_W       = 20;
    localparam int              CNT_W        = $clog2(QUOT_W + 1);
    localparam logic [QUOT_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [RPM_W-1:0]  RPM_FACTOR   = 26'd60;

    // Configuration port geometry and reset values.
    localparam int                 ADDR_W        = 5;
    localparam int                 DATA_W        = 32;
    localparam logic [CPR_W-1:0]   CPR_RESET     = 16'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000000;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_ENABLE_1 = 3'd0,
        REG_ENABLE_2 = 3'd1,
        REG_CPR_1    = 3'd2,
        REG_CPR_2    = 3'd3,
        REG_TIMEOUT  = 3'd4
    } dep_reg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STALL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } dep_state_t;

    // One sampled tick from both encoders.
    typedef struct packed {
        logic a_level_1;
        logic b_level_1;
        logic a_level_2;
        logic b_level_2;
    } dep_in_t;

    // One result per tick.
    typedef struct packed {
        logic signed [POS_W-1:0] position_1;
        logic signed [POS_W-1:0] position_2;
        logic [RPM_W-1:0]        rpm_1;
        logic [RPM_W-1:0]        rpm_2;
    } dep_out_t;

    // Configuration register contents.
    typedef struct packed {
        logic                 enable_1;
        logic                 enable_2;
        logic [CPR_W-1:0]     counts_per_rev_1;
        logic [CPR_W-1:0]     counts_per_rev_2;
        logic [TIMEOUT_W-1:0] stall_timeout_us;
    } dep_cfg_t;

endpackage

[design/dep_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
module dep_divider #(
    parameter int DIV_W = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [dep_pkg::QUOT_W-1:0] dividend,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       busy,
    output logic                       done,
    output logic [dep_pkg::QUOT_W-1:0] quotient
);
    import dep_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                fits;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {rem_reg, quo_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // One iteration per cycle; the dividend shifts out as quotient bits shift in.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[QUOT_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/dep_regs.sv]
// Configuration register file behind the APB-style port.
module dep_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dep_pkg::ADDR_W-1:0] paddr,
    input  logic [dep_pkg::DATA_W-1:0] pwdata,
    output logic [dep_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dep_pkg::dep_cfg_t          cfg
);
    import dep_pkg::*;

    dep_cfg_t     cfg_reg, cfg_next;
    dep_reg_idx_t idx;
    logic         wr_en;

    assign idx   = dep_reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_1         <= 1'b0;
            cfg_reg.enable_2         <= 1'b0;
            cfg_reg.counts_per_rev_1 <= CPR_RESET;
            cfg_reg.counts_per_rev_2 <= CPR_RESET;
            cfg_reg.stall_timeout_us <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Write decode; addresses past the last register are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_ENABLE_1: cfg_next.enable_1         = pwdata[0];
                REG_ENABLE_2: cfg_next.enable_2         = pwdata[0];
                REG_CPR_1:    cfg_next.counts_per_rev_1 = pwdata[CPR_W-1:0];
                REG_CPR_2:    cfg_next.counts_per_rev_2 = pwdata[CPR_W-1:0];
                REG_TIMEOUT:  cfg_next.stall_timeout_us = pwdata[TIMEOUT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Read decode.
    always_comb begin
        unique case (idx)
            REG_ENABLE_1: prdata = DATA_W'(cfg_reg.enable_1);
            REG_ENABLE_2: prdata = DATA_W'(cfg_reg.enable_2);
            REG_CPR_1:    prdata = DATA_W'(cfg_reg.counts_per_rev_1);
            REG_CPR_2:    prdata = DATA_W'(cfg_reg.counts_per_rev_2);
            REG_TIMEOUT:  prdata = DATA_W'(cfg_reg.stall_timeout_us);
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

[design/dual_encoder_position_speed.sv]
// Each input transfer yields one result. A channel with a nonzero period and counts_per_rev
// gets its speed from two passes through the single shared divider, and the channels are
// served one after the other. No new tick is taken before the result of the last one has
// entered the output register.
// A new tick is taken while the previous result still waits on the output register.
// Reset (aresetn low, synchronous) zeroes positions, times, periods and the clock.
module dual_encoder_position_speed #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  dep_pkg::dep_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output dep_pkg::dep_out_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dep_pkg::ADDR_W-1:0] paddr,
    input  logic [dep_pkg::DATA_W-1:0] pwdata,
    output logic [dep_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import dep_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;

    dep_cfg_t   cfg;
    dep_state_t state_reg, state_next;
    logic       ch_reg, ch_next;
    logic       stage_reg, stage_next;

    logic [TIME_WIDTH-1:0]   usec_reg, usec_next;
    logic [TIME_WIDTH-1:0]   last_reg   [NUM_CH];
    logic [TIME_WIDTH-1:0]   last_next  [NUM_CH];
    logic [TIME_WIDTH-1:0]   period_reg [NUM_CH];
    logic [TIME_WIDTH-1:0]   period_next[NUM_CH];
    logic signed [POS_W-1:0] pos_reg    [NUM_CH];
    logic signed [POS_W-1:0] pos_next   [NUM_CH];
    logic                    prev_a_reg [NUM_CH];
    logic                    prev_a_next[NUM_CH];
    logic [RPM_W-1:0]        rpm_reg    [NUM_CH];
    logic [RPM_W-1:0]        rpm_next   [NUM_CH];
    logic [QUOT_W-1:0]       quo1_reg, quo1_next;
    logic                    m_valid_reg, m_valid_next;
    dep_out_t                m_data_reg, m_data_next;

    logic                    a_in  [NUM_CH];
    logic                    b_in  [NUM_CH];
    logic                    en    [NUM_CH];
    logic [TIME_WIDTH-1:0]   elapsed[NUM_CH];
    logic [CPR_W-1:0]        counts_sel;
    logic [TIME_WIDTH-1:0]   period_sel;
    logic                    in_xfer;
    logic                    out_load;
    logic                    skip;

    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [QUOT_W-1:0]       div_dividend;
    logic [TIME_WIDTH-1:0]   div_divisor;
    logic [QUOT_W-1:0]       div_quotient;

    // Configuration registers.
    dep_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Divider shared by both channels and both division steps.
    dep_divider #(
        .DIV_W (TIME_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Per-channel views of the inputs and configuration.
    assign a_in[0] = s_data.a_level_1;
    assign b_in[0] = s_data.b_level_1;
    assign a_in[1] = s_data.a_level_2;
    assign b_in[1] = s_data.b_level_2;
    assign en[0]   = cfg.enable_1;
    assign en[1]   = cfg.enable_2;

    assign counts_sel = ch_reg ? cfg.counts_per_rev_2 : cfg.counts_per_rev_1;
    assign period_sel = period_reg[ch_reg];

    // A channel with no period or no counts per revolution skips its divisions.
    assign skip = !stage_reg && ((period_sel == '0) || (counts_sel == '0));

    // First pass divides one second by the period, second pass divides by the counts.
    assign div_dividend = stage_reg ? quo1_reg : USEC_PER_SEC;
    assign div_divisor  = stage_reg ? TIME_WIDTH'(counts_sel) : period_sel;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= 1'b0;
            stage_reg   <= 1'b0;
            usec_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                last_reg[c]   <= '0;
                period_reg[c] <= '0;
                pos_reg[c]    <= '0;
                prev_a_reg[c] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            stage_reg   <= stage_next;
            usec_reg    <= usec_next;
            m_valid_reg <= m_valid_next;
            for (int c = 0; c < NUM_CH; c++) begin
                last_reg[c]   <= last_next[c];
                period_reg[c] <= period_next[c];
                pos_reg[c]    <= pos_next[c];
                prev_a_reg[c] <= prev_a_next[c];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        quo1_reg   <= quo1_next;
        m_data_reg <= m_data_next;
        for (int c = 0; c < NUM_CH; c++) begin
            rpm_reg[c] <= rpm_next[c];
        end
    end

    // Sequencer: next state and divider start.
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_STALL;
                end
            end
            ST_STALL: begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                if (skip) begin
                    state_next = ch_reg ? ST_DONE : ST_DIV_START;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (stage_reg && ch_reg) ? ST_DONE : ST_DIV_START;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath: edge capture, stall check, speed results and output register.
    always_comb begin
        ch_next      = ch_reg;
        stage_next   = stage_reg;
        usec_next    = usec_reg;
        quo1_next    = quo1_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        for (int c = 0; c < NUM_CH; c++) begin
            last_next[c]   = last_reg[c];
            period_next[c] = period_reg[c];
            pos_next[c]    = pos_reg[c];
            prev_a_next[c] = prev_a_reg[c];
            rpm_next[c]    = rpm_reg[c];
            elapsed[c]     = usec_reg - last_reg[c];
        end

        // A rising edge of A on an enabled channel counts and measures its period.
        if (in_xfer) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (en[c] && !prev_a_reg[c] && a_in[c]) begin
                    period_next[c] = usec_reg - last_reg[c];
                    last_next[c]   = usec_reg;
                    pos_next[c]    = b_in[c] ? (pos_reg[c] + 32'sd1) : (pos_reg[c] - 32'sd1);
                end
                prev_a_next[c] = a_in[c];
            end
        end

        // A channel quiet for longer than the timeout loses its period.
        if (state_reg == ST_STALL) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (CMP_W'(elapsed[c]) > CMP_W'(cfg.stall_timeout_us)) begin
                    period_next[c] = '0;
                end
            end
        end

        // Skipped channel reads zero speed.
        if ((state_reg == ST_DIV_START) && skip) begin
            rpm_next[ch_reg] = '0;
            ch_next          = ~ch_reg;
        end

        // Collect each division result.
        if ((state_reg == ST_DIV_WAIT) && div_done) begin
            if (!stage_reg) begin
                quo1_next  = div_quotient;
                stage_next = 1'b1;
            end else begin
                rpm_next[ch_reg] = RPM_W'(RPM_W'(div_quotient) * RPM_FACTOR);
                stage_next       = 1'b0;
                ch_next          = ~ch_reg;
            end
        end

        // Result transfer and clock advance.
        if (out_load) begin
            m_valid_next            = 1'b1;
            m_data_next.position_1  = pos_reg[0];
            m_data_next.position_2  = pos_reg[1];
            m_data_next.rpm_1       = rpm_reg[0];
            m_data_next.rpm_2       = rpm_reg[1];
            usec_next               = usec_reg + TIME_WIDTH'(1);
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // No new tick is taken while a division is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn) div_busy |-> !s_ready)
        else $error("input transfer possible while divider busy");

    // Divider completion is only seen by the sequencer while it waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider result arrived outside the wait state");

    // The second division step exists only inside the division states.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg |-> ((state_reg == ST_DIV_START) || (state_reg == ST_DIV_WAIT)))
        else $error("division stage left set outside the division states");

    // A result load always presents a valid transfer in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) out_load |=> m_valid)
        else $error("result load did not raise m_valid");

endmodule
